// ===== design/wlm_pkg.sv =====
// ----------------------------------------------------------------------------
// wlm_pkg
// Shared types and constants for the water level monitor: register map,
// level classes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wlm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DUTY_BITS   = 10;
  localparam int PCT_BITS    = 7;
  localparam int ADDR_BITS   = 5;
  localparam int NUM_BITS    = SAMPLE_BITS + PCT_BITS;
  localparam int CNT_BITS    = 3;

  localparam logic [DUTY_BITS-1:0] DUTY_LIMIT   = 10'd999;
  localparam logic [PCT_BITS-1:0]  PERCENT_FULL = 7'd100;
  localparam logic [CNT_BITS-1:0]  DIV_FIRST    = 3'(PCT_BITS - 1);

  localparam logic [2:0] REG_PCT_LOW   = 3'd0;
  localparam logic [2:0] REG_PCT_HIGH  = 3'd1;
  localparam logic [2:0] REG_DRY       = 3'd2;
  localparam logic [2:0] REG_MID       = 3'd3;
  localparam logic [2:0] REG_HIGH      = 3'd4;
  localparam logic [2:0] REG_INVERT    = 3'd5;
  localparam logic [2:0] REG_FULL      = 3'd6;
  localparam logic [2:0] REG_DUTY      = 3'd7;

  localparam logic [1:0] CLASS_DRY  = 2'd0;
  localparam logic [1:0] CLASS_LOW  = 2'd1;
  localparam logic [1:0] CLASS_MID  = 2'd2;
  localparam logic [1:0] CLASS_HIGH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCALE,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pct_low;
    logic [SAMPLE_BITS-1:0] pct_high;
    logic [SAMPLE_BITS-1:0] dry_th;
    logic [SAMPLE_BITS-1:0] mid_th;
    logic [SAMPLE_BITS-1:0] high_th;
    logic                   invert;
    logic [SAMPLE_BITS-1:0] full_scale;
    logic [DUTY_BITS-1:0]   duty;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic read;
    logic scale;
    logic div_step;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

// ===== design/wlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wlm_ctrl
// Sequencer for one item: load, reading, scaling, division steps and the
// hand-off into the output register, plus the output valid flag.
// ----------------------------------------------------------------------------
module wlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wlm_pkg::cmd_t     cmd,
  input  wlm_pkg::status_t  status
);

  wlm_pkg::state_t state;
  wlm_pkg::state_t state_next;
  logic            out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      wlm_pkg::S_IDLE:   if (in_valid) state_next = wlm_pkg::S_READ;
      wlm_pkg::S_READ:   state_next = wlm_pkg::S_SCALE;
      wlm_pkg::S_SCALE:  state_next = wlm_pkg::S_DIV;
      wlm_pkg::S_DIV:    if (status.div_last) state_next = wlm_pkg::S_FINISH;
      wlm_pkg::S_FINISH: if (!out_valid || out_ready) state_next = wlm_pkg::S_IDLE;
      default:           state_next = wlm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      wlm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wlm_pkg::S_READ:   cmd.read = 1'b1;
      wlm_pkg::S_SCALE:  cmd.scale = 1'b1;
      wlm_pkg::S_DIV:    cmd.div_step = 1'b1;
      wlm_pkg::S_FINISH: cmd.out_write = !out_valid || out_ready;
      default:           cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.out_write) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/wlm_datapath.sv =====
// ----------------------------------------------------------------------------
// wlm_datapath
// Running average, inversion, classification, percent scaling with a
// one-bit-per-cycle restoring divider, and the output register.
// ----------------------------------------------------------------------------
module wlm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  wlm_pkg::cmd_t                       cmd,
  output wlm_pkg::status_t                    status,
  input  wlm_pkg::cfg_t                       cfg,
  input  logic [wlm_pkg::SAMPLE_BITS-1:0]     sample,
  output logic [wlm_pkg::SAMPLE_BITS-1:0]     filtered_value,
  output logic [wlm_pkg::PCT_BITS-1:0]        percent,
  output logic [1:0]                          level_class,
  output logic [wlm_pkg::DUTY_BITS-1:0]       red_duty,
  output logic [wlm_pkg::DUTY_BITS-1:0]       yellow_duty,
  output logic [wlm_pkg::DUTY_BITS-1:0]       green_duty
);

  logic [wlm_pkg::SAMPLE_BITS-1:0] avg;
  logic [wlm_pkg::SAMPLE_BITS+1:0] avg_sum;
  logic [wlm_pkg::SAMPLE_BITS-1:0] reading;
  logic [wlm_pkg::SAMPLE_BITS-1:0] reading_next;
  logic [1:0]                      cls;
  logic [1:0]                      cls_next;
  logic                            pct_zero;
  logic                            pct_full;
  logic [wlm_pkg::SAMPLE_BITS-1:0] span;
  logic [wlm_pkg::SAMPLE_BITS-1:0] offset;
  logic [wlm_pkg::NUM_BITS-1:0]    numer;
  logic [wlm_pkg::NUM_BITS-1:0]    rem;
  logic [wlm_pkg::NUM_BITS-1:0]    dvs;
  logic [wlm_pkg::PCT_BITS-1:0]    quot;
  logic [wlm_pkg::CNT_BITS-1:0]    cnt;
  logic [wlm_pkg::DUTY_BITS-1:0]   duty;
  logic [wlm_pkg::PCT_BITS-1:0]    pct_final;

  assign avg_sum = {2'b00, avg} + {1'b0, avg, 1'b0} + {2'b00, sample};

  always_comb begin
    reading_next = avg;
    if (cfg.invert) begin
      reading_next = (cfg.full_scale > avg) ? (cfg.full_scale - avg) : '0;
    end
    if (reading_next < cfg.dry_th) begin
      cls_next = wlm_pkg::CLASS_DRY;
    end else if (reading_next < cfg.mid_th) begin
      cls_next = wlm_pkg::CLASS_LOW;
    end else if (reading_next < cfg.high_th) begin
      cls_next = wlm_pkg::CLASS_MID;
    end else begin
      cls_next = wlm_pkg::CLASS_HIGH;
    end
  end

  assign span   = cfg.pct_high - cfg.pct_low;
  assign offset = reading - cfg.pct_low;
  assign numer  = wlm_pkg::NUM_BITS'(offset) * wlm_pkg::NUM_BITS'(wlm_pkg::PERCENT_FULL)
                + wlm_pkg::NUM_BITS'(span >> 1);

  assign status.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (cmd.load) begin
      avg <= (avg == '0) ? sample : avg_sum[wlm_pkg::SAMPLE_BITS+1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      reading <= reading_next;
      cls     <= cls_next;
    end
    if (cmd.scale) begin
      pct_zero <= (cfg.pct_high <= cfg.pct_low) || (reading <= cfg.pct_low);
      pct_full <= (reading >= cfg.pct_high);
      rem      <= numer;
      dvs      <= {span, {wlm_pkg::PCT_BITS-1{1'b0}}, 1'b0} >> 1;
      quot     <= '0;
      cnt      <= wlm_pkg::DIV_FIRST;
    end
    if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem  <= rem - dvs;
        quot <= {quot[wlm_pkg::PCT_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[wlm_pkg::PCT_BITS-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign duty = (cfg.duty > wlm_pkg::DUTY_LIMIT) ? wlm_pkg::DUTY_LIMIT : cfg.duty;

  always_comb begin
    if (pct_zero) begin
      pct_final = '0;
    end else if (pct_full) begin
      pct_final = wlm_pkg::PERCENT_FULL;
    end else begin
      pct_final = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      filtered_value <= avg;
      percent        <= pct_final;
      level_class    <= cls;
      red_duty       <= '0;
      yellow_duty    <= '0;
      green_duty     <= '0;
      case (cls)
        wlm_pkg::CLASS_LOW: green_duty  <= duty;
        wlm_pkg::CLASS_MID: yellow_duty <= duty;
        default:            red_duty    <= duty;
      endcase
    end
  end

endmodule

// ===== design/water_level_monitor.sv =====
// ----------------------------------------------------------------------------
// water_level_monitor
// Smooths water-sensor samples with a running average and reports the level
// as a percent, a class and red/yellow/green indicator duties.
// ----------------------------------------------------------------------------
// One sample item enters on the input channel (in_valid/in_ready) and one
// result item leaves on the output channel (out_valid/out_ready).
// The block works on one item at a time. The restoring divider of the
// percent scaling finds one quotient bit per cycle. A new item can be
// accepted in the cycle after the result is loaded.
// The result waits in an output register. While the receiver stalls, the
// next item is still accepted and processed; it then holds in the final
// step until the waiting result is taken.
// Reset clears the running average (so the next sample loads it), the
// handshake state, and returns all configuration registers to their
// defaults. Configuration is written over the APB port; the user must see that
// it is changed only while no item is in flight. The block does not enforce it.
// ----------------------------------------------------------------------------
module water_level_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wlm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wlm_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wlm_pkg::SAMPLE_BITS-1:0]   filtered_value,
  output logic [wlm_pkg::PCT_BITS-1:0]      percent,
  output logic [1:0]                        level_class,
  output logic [wlm_pkg::DUTY_BITS-1:0]     red_duty,
  output logic [wlm_pkg::DUTY_BITS-1:0]     yellow_duty,
  output logic [wlm_pkg::DUTY_BITS-1:0]     green_duty
);

  wlm_pkg::cfg_t    cfg;
  wlm_pkg::cmd_t    cmd;
  wlm_pkg::status_t status;
  logic [2:0]       reg_index;
  logic             wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[wlm_pkg::ADDR_BITS-1:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pct_low    <= 12'd1200;
      cfg.pct_high   <= 12'd1900;
      cfg.dry_th     <= 12'd1200;
      cfg.mid_th     <= 12'd1600;
      cfg.high_th    <= 12'd1900;
      cfg.invert     <= 1'b0;
      cfg.full_scale <= 12'd4095;
      cfg.duty       <= 10'd500;
    end else if (wr_en) begin
      case (reg_index)
        wlm_pkg::REG_PCT_LOW:  cfg.pct_low    <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_PCT_HIGH: cfg.pct_high   <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_DRY:      cfg.dry_th     <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_MID:      cfg.mid_th     <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_HIGH:     cfg.high_th    <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_INVERT:   cfg.invert     <= pwdata[0];
        wlm_pkg::REG_FULL:     cfg.full_scale <= pwdata[wlm_pkg::SAMPLE_BITS-1:0];
        wlm_pkg::REG_DUTY:     cfg.duty       <= pwdata[wlm_pkg::DUTY_BITS-1:0];
        default:               cfg.duty       <= cfg.duty;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      wlm_pkg::REG_PCT_LOW:  prdata = 32'(cfg.pct_low);
      wlm_pkg::REG_PCT_HIGH: prdata = 32'(cfg.pct_high);
      wlm_pkg::REG_DRY:      prdata = 32'(cfg.dry_th);
      wlm_pkg::REG_MID:      prdata = 32'(cfg.mid_th);
      wlm_pkg::REG_HIGH:     prdata = 32'(cfg.high_th);
      wlm_pkg::REG_INVERT:   prdata = 32'(cfg.invert);
      wlm_pkg::REG_FULL:     prdata = 32'(cfg.full_scale);
      wlm_pkg::REG_DUTY:     prdata = 32'(cfg.duty);
      default:               prdata = '0;
    endcase
  end

  wlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  wlm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg),
    .sample         (sample),
    .filtered_value (filtered_value),
    .percent        (percent),
    .level_class    (level_class),
    .red_duty       (red_duty),
    .yellow_duty    (yellow_duty),
    .green_duty     (green_duty)
  );

endmodule

// ===== sim/tb_water_level_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_water_level_monitor
// Self-checking bench for the water level monitor. A short table of directed
// samples and register writes covers the corner cases, then phases of random
// samples run under fixed and random register settings. Every result item is
// compared with its table row where given, else with an in-bench model of the
// averaging, inversion, percent scaling, level classing and indicator selection.
// ----------------------------------------------------------------------------
module tb_water_level_monitor;

  localparam int NUM_PHASES      = 16;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 24;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [wlm_pkg::SAMPLE_BITS-1:0] filtered;
    logic [wlm_pkg::PCT_BITS-1:0]    pct;
    logic [1:0]                      level;
    logic [wlm_pkg::DUTY_BITS-1:0]   red;
    logic [wlm_pkg::DUTY_BITS-1:0]   yellow;
    logic [wlm_pkg::DUTY_BITS-1:0]   green;
  } level_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [2:0]                      reg_idx;
    logic [wlm_pkg::SAMPLE_BITS-1:0] value;
    bit                              typed;
    level_result_t                   want;
  } plan_row_t;

  localparam level_result_t UNCHECKED = '0;
  localparam logic [2:0]    NO_REG    = 3'd0;

  localparam wlm_pkg::cfg_t CFG_RESET = '{pct_low: 12'd1200, pct_high: 12'd1900,
                                          dry_th: 12'd1200, mid_th: 12'd1600,
                                          high_th: 12'd1900, invert: 1'b0,
                                          full_scale: 12'd4095, duty: 10'd500};

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [wlm_pkg::ADDR_BITS-1:0]   paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;
  logic                            in_valid;
  logic                            in_ready;
  logic [wlm_pkg::SAMPLE_BITS-1:0] sample;
  logic                            out_valid;
  logic                            out_ready;
  logic [wlm_pkg::SAMPLE_BITS-1:0] filtered_value;
  logic [wlm_pkg::PCT_BITS-1:0]    percent;
  logic [1:0]                      level_class;
  logic [wlm_pkg::DUTY_BITS-1:0]   red_duty;
  logic [wlm_pkg::DUTY_BITS-1:0]   yellow_duty;
  logic [wlm_pkg::DUTY_BITS-1:0]   green_duty;

  wlm_pkg::cfg_t                   cfg_model = CFG_RESET;
  logic [wlm_pkg::SAMPLE_BITS-1:0] level_avg = '0;
  level_result_t                   expected_levels[$];
  int                              mismatches = 0;
  int                              idle_cycles = 0;
  int                              zero_run = 0;
  bit                              fast_in = 1'b0;
  bit                              fast_out = 1'b0;
  bit                              hold_out = 1'b0;
  bit                              row_typed = 1'b0;
  level_result_t                   row_want = '0;

  plan_row_t plan_rows[] = '{
    '{ROW_ITEM, NO_REG, 12'd0, 1'b1,
      '{12'd0, 7'd0, wlm_pkg::CLASS_DRY, 10'd500, 10'd0, 10'd0}},
    '{ROW_ITEM, NO_REG, 12'd4095, 1'b1,
      '{12'd4095, 7'd100, wlm_pkg::CLASS_HIGH, 10'd500, 10'd0, 10'd0}},
    '{ROW_ITEM, NO_REG, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd1600, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd1, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_INVERT, 12'd1, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_FULL, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd2048, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_FULL, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_INVERT, 12'd0, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_LOW, 12'd2000, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_HIGH, 12'd2000, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd3000, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_LOW, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_HIGH, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd1000, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_LOW, 12'd0, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_PCT_HIGH, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd2047, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd4094, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DRY, 12'd3000, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_MID, 12'd100, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_HIGH, 12'd50, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd2500, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DUTY, 12'd1023, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd1200, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DUTY, 12'd1000, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd100, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DUTY, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd3500, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DUTY, 12'd999, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DRY, 12'd0, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_MID, 12'd0, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_HIGH, 12'd0, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd2222, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_DRY, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_MID, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_CFG, wlm_pkg::REG_HIGH, 12'd4095, 1'b0, UNCHECKED},
    '{ROW_ITEM, NO_REG, 12'd4095, 1'b0, UNCHECKED}
  };

  water_level_monitor u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic level_result_t grade_sample(input logic [wlm_pkg::SAMPLE_BITS-1:0] s);
    level_result_t                   r;
    logic [wlm_pkg::SAMPLE_BITS-1:0] reading;
    logic [wlm_pkg::DUTY_BITS-1:0]   duty;
    int unsigned                     rd;
    int unsigned                     lo;
    int unsigned                     hi;
    int unsigned                     span;
    if (level_avg == '0) begin
      level_avg = s;
    end else begin
      level_avg = wlm_pkg::SAMPLE_BITS'((3 * int'(level_avg) + int'(s)) / 4);
    end
    reading = level_avg;
    if (cfg_model.invert) begin
      reading = (cfg_model.full_scale > level_avg) ? cfg_model.full_scale - level_avg : '0;
    end
    if (reading < cfg_model.dry_th) begin
      r.level = wlm_pkg::CLASS_DRY;
    end else if (reading < cfg_model.mid_th) begin
      r.level = wlm_pkg::CLASS_LOW;
    end else if (reading < cfg_model.high_th) begin
      r.level = wlm_pkg::CLASS_MID;
    end else begin
      r.level = wlm_pkg::CLASS_HIGH;
    end
    duty = (cfg_model.duty > wlm_pkg::DUTY_LIMIT) ? wlm_pkg::DUTY_LIMIT : cfg_model.duty;
    r.red = '0;
    r.yellow = '0;
    r.green = '0;
    case (r.level)
      wlm_pkg::CLASS_LOW: r.green = duty;
      wlm_pkg::CLASS_MID: r.yellow = duty;
      default: r.red = duty;
    endcase
    rd = reading;
    lo = cfg_model.pct_low;
    hi = cfg_model.pct_high;
    if (hi <= lo || rd <= lo) begin
      r.pct = '0;
    end else if (rd >= hi) begin
      r.pct = wlm_pkg::PERCENT_FULL;
    end else begin
      span = hi - lo;
      r.pct = wlm_pkg::PCT_BITS'(((rd - lo) * wlm_pkg::PERCENT_FULL + span / 2) / span);
    end
    r.filtered = level_avg;
    return r;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      wlm_pkg::REG_PCT_LOW: cfg_model.pct_low = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_PCT_HIGH: cfg_model.pct_high = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_DRY: cfg_model.dry_th = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_MID: cfg_model.mid_th = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_HIGH: cfg_model.high_th = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_INVERT: cfg_model.invert = val[0];
      wlm_pkg::REG_FULL: cfg_model.full_scale = val[wlm_pkg::SAMPLE_BITS-1:0];
      wlm_pkg::REG_DUTY: cfg_model.duty = val[wlm_pkg::DUTY_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [wlm_pkg::SAMPLE_BITS-1:0] pick_value(input int unsigned top);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return wlm_pkg::SAMPLE_BITS'(top);
      default: return wlm_pkg::SAMPLE_BITS'($urandom_range(0, top));
    endcase
  endfunction

  // Zero runs let the average decay all the way to zero so the next sample reloads it.
  function automatic logic [wlm_pkg::SAMPLE_BITS-1:0] next_sample();
    int pick;
    int near;
    if (zero_run > 0) begin
      zero_run--;
      return '0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      zero_run = $urandom_range(25, 40);
      return '0;
    end
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: return 12'd0;
        1: return 12'd4095;
        2: return 12'd1;
        default: return 12'd4094;
      endcase
    end
    if (pick < 35) begin
      case ($urandom_range(0, 4))
        0: near = cfg_model.dry_th;
        1: near = cfg_model.mid_th;
        2: near = cfg_model.high_th;
        3: near = cfg_model.pct_low;
        default: near = cfg_model.pct_high;
      endcase
      near += int'($urandom_range(0, 16)) - 8;
      if (near < 0) near = 0;
      if (near > 4095) near = 4095;
      return wlm_pkg::SAMPLE_BITS'(near);
    end
    return wlm_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_setting(idx, val);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_sample(input logic [wlm_pkg::SAMPLE_BITS-1:0] s, input bit typed,
                             input level_result_t want);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_typed = typed;
    row_want = want;
    sample <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic choose_settings(input int phase);
    logic [wlm_pkg::SAMPLE_BITS-1:0] vals [8];
    logic [wlm_pkg::SAMPLE_BITS-1:0] t;
    case (phase)
      0: begin
        vals[wlm_pkg::REG_PCT_LOW] = CFG_RESET.pct_low;
        vals[wlm_pkg::REG_PCT_HIGH] = CFG_RESET.pct_high;
        vals[wlm_pkg::REG_DRY] = CFG_RESET.dry_th;
        vals[wlm_pkg::REG_MID] = CFG_RESET.mid_th;
        vals[wlm_pkg::REG_HIGH] = CFG_RESET.high_th;
        vals[wlm_pkg::REG_INVERT] = wlm_pkg::SAMPLE_BITS'(CFG_RESET.invert);
        vals[wlm_pkg::REG_FULL] = CFG_RESET.full_scale;
        vals[wlm_pkg::REG_DUTY] = wlm_pkg::SAMPLE_BITS'(CFG_RESET.duty);
      end
      1: begin
        foreach (vals[i]) vals[i] = '0;
      end
      2: begin
        foreach (vals[i]) vals[i] = 12'd4095;
        vals[wlm_pkg::REG_INVERT] = 12'd1;
        vals[wlm_pkg::REG_DUTY] = 12'd1023;
      end
      default: begin
        vals[wlm_pkg::REG_PCT_LOW] = pick_value(4095);
        vals[wlm_pkg::REG_PCT_HIGH] = pick_value(4095);
        if ($urandom_range(0, 3) != 0 &&
            vals[wlm_pkg::REG_PCT_LOW] > vals[wlm_pkg::REG_PCT_HIGH]) begin
          t = vals[wlm_pkg::REG_PCT_LOW];
          vals[wlm_pkg::REG_PCT_LOW] = vals[wlm_pkg::REG_PCT_HIGH];
          vals[wlm_pkg::REG_PCT_HIGH] = t;
        end
        vals[wlm_pkg::REG_DRY] = pick_value(4095);
        vals[wlm_pkg::REG_MID] = pick_value(4095);
        vals[wlm_pkg::REG_HIGH] = pick_value(4095);
        if ($urandom_range(0, 3) != 0) begin
          if (vals[wlm_pkg::REG_DRY] > vals[wlm_pkg::REG_MID]) begin
            t = vals[wlm_pkg::REG_DRY];
            vals[wlm_pkg::REG_DRY] = vals[wlm_pkg::REG_MID];
            vals[wlm_pkg::REG_MID] = t;
          end
          if (vals[wlm_pkg::REG_MID] > vals[wlm_pkg::REG_HIGH]) begin
            t = vals[wlm_pkg::REG_MID];
            vals[wlm_pkg::REG_MID] = vals[wlm_pkg::REG_HIGH];
            vals[wlm_pkg::REG_HIGH] = t;
          end
          if (vals[wlm_pkg::REG_DRY] > vals[wlm_pkg::REG_MID]) begin
            t = vals[wlm_pkg::REG_DRY];
            vals[wlm_pkg::REG_DRY] = vals[wlm_pkg::REG_MID];
            vals[wlm_pkg::REG_MID] = t;
          end
        end
        vals[wlm_pkg::REG_INVERT] = wlm_pkg::SAMPLE_BITS'($urandom_range(0, 1));
        vals[wlm_pkg::REG_FULL] = pick_value(4095);
        vals[wlm_pkg::REG_DUTY] = pick_value(1023);
      end
    endcase
    foreach (vals[i]) write_reg(3'(i), 32'(vals[i]));
  endtask

  always @(posedge clk) begin : level_checker
    level_result_t got;
    level_result_t want;
    bit            busy;
    if (!rst) begin
      busy = 1'b0;
      if (out_valid && out_ready) begin
        busy = 1'b1;
        got = '{filtered_value, percent, level_class, red_duty, yellow_duty, green_duty};
        if (expected_levels.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected result item: avg=%0d pct=%0d class=%0d r/y/g=%0d/%0d/%0d",
                     got.filtered, got.pct, got.level, got.red, got.yellow, got.green);
          end
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("result mismatch: expected avg=%0d pct=%0d class=%0d r/y/g=%0d/%0d/%0d",
                       want.filtered, want.pct, want.level, want.red, want.yellow, want.green);
              $display("                 actual   avg=%0d pct=%0d class=%0d r/y/g=%0d/%0d/%0d",
                       got.filtered, got.pct, got.level, got.red, got.yellow, got.green);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        busy = 1'b1;
        want = grade_sample(sample);
        expected_levels.push_back(row_typed ? row_want : want);
      end
      if (psel && penable && pwrite && pready) busy = 1'b1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_water_level_monitor NOT OK");
        $finish;
      end
    end
  end

  initial begin : result_taker
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_out) begin
        stall = HOLD_CYCLES;
        hold_out = 1'b0;
      end else begin
        stall = fast_out ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    sample = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(plan_rows[i].reg_idx, 32'(plan_rows[i].value));
      end else begin
        send_sample(plan_rows[i].value, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      choose_settings(p);
      fast_in = ($urandom_range(0, 3) == 0);
      fast_out = ($urandom_range(0, 3) == 0);
      // The receiver stalls for a long stretch while samples keep coming.
      if (p == HOLD_PHASE) begin
        fast_in = 1'b1;
        hold_out = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_sample(next_sample(), 1'b0, UNCHECKED);
    end

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_water_level_monitor OK");
    end else begin
      $display("tb_water_level_monitor NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wlm_pkg.sv
design/wlm_ctrl.sv
design/wlm_datapath.sv
design/water_level_monitor.sv
sim/tb_water_level_monitor.sv
